@@ rtl/lwcc_pkg.sv @@
`default_nettype none
package lwcc_pkg;

    localparam int LogTableBits = 8;
    localparam int TableSize    = 1 << LogTableBits;
    localparam int Ln2Q12       = 2839;
    localparam logic [15:0] LogWeightReset = 16'd18432;
    localparam logic [23:0] WsumMax = 24'hFFFFFF;
    localparam logic signed [39:0] PsumMax = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] PsumMin = {1'b1, {39{1'b0}}};
    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    typedef struct packed {
        logic signed [15:0] digit_x;
        logic signed [15:0] digit_z;
        logic [23:0]        digit_energy;
        logic [23:0]        cluster_amplitude;
        logic               last_digit;
    } lwcc_in_t;

    typedef struct packed {
        logic signed [15:0] centroid_x;
        logic signed [15:0] centroid_z;
        logic               position_valid;
    } lwcc_out_t;

    // one finished cluster handed from front to back
    typedef struct packed {
        logic signed [39:0] sum_x;
        logic signed [39:0] sum_z;
        logic [23:0]        sum_w;
    } lwcc_job_t;

    typedef logic [11:0] ln_table_t [TableSize];

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(4096*ln(1+f/256)) computed at elaboration from the atanh series
    function automatic logic [11:0] ln_frac(input logic [LogTableBits-1:0] f);
        longint unsigned y;
        longint unsigned y2;
        longint unsigned p;
        longint unsigned acc;
        longint unsigned i;
        i   = 64'(f);
        y   = udiv(i << 32, 64'(2 * TableSize) + i);
        y2  = (y * y) >> 32;
        p   = y;
        acc = 0;
        for (int n = 0; n < 16; n++) begin
            acc = acc + udiv(p, 64'(2 * n + 1));
            p   = (p * y2) >> 32;
        end
        return 12'((2 * acc + (64'd1 << 19)) >> 20);
    endfunction

    function automatic ln_table_t build_ln_table();
        ln_table_t t;
        for (int i = 0; i < TableSize; i++) begin
            t[i] = ln_frac(LogTableBits'(i));
        end
        return t;
    endfunction

    localparam ln_table_t LnTable = build_ln_table();

endpackage
`default_nettype wire

@@ rtl/log_weighted_cluster_centroid.sv @@
`default_nettype none
// channel  | ports            | payload
// input    | s_valid/s_ready  | s_data (lwcc_in_t)
// result   | m_valid/m_ready  | m_data (lwcc_out_t), one per last digit
// config   | cfg_we/cfg_wdata | log_weight
// digits enter one per cycle while s_ready is high; the front pipeline is two stages deep
// each cluster end queues its sums; the back part takes one cluster at a time
// (40 divide steps), then a finish state, and the centroid shows in the output state
// s_ready drops for one cycle after a last digit and while the queue is full
// synchronous active-low reset clears sums, queue and log_weight to 4.5
module log_weighted_cluster_centroid (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  lwcc_pkg::lwcc_in_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output lwcc_pkg::lwcc_out_t m_data,
    input  wire                 cfg_we,
    input  wire [15:0]          cfg_wdata
);
    import lwcc_pkg::*;

    logic [15:0] log_weight_reg;
    logic        q_push, q_full, q_ne, q_pop;
    lwcc_job_t   q_in, q_out;

    // offset register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_weight_reg <= LogWeightReset;
        end else if (cfg_we) begin
            log_weight_reg <= cfg_wdata;
        end
    end

    lwcc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_data(s_data),
        .log_weight(log_weight_reg), .q_full(q_full), .in_ready(s_ready),
        .q_push(q_push), .q_data(q_in)
    );

    lwcc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_data(q_in),
        .full(q_full), .not_empty(q_ne), .pop(q_pop), .pop_data(q_out)
    );

    // back end: division and clamping
    lwcc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(q_ne), .job(q_out),
        .job_pop(q_pop), .out_valid(m_valid), .out_ready(m_ready), .out_data(m_data)
    );
endmodule
`default_nettype wire

@@ rtl/lwcc_front.sv @@
`default_nettype none
module lwcc_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    input  lwcc_pkg::lwcc_in_t   in_data,
    input  wire [15:0]           log_weight,
    input  wire                  q_full,
    output logic                 in_ready,
    output logic                 q_push,
    output lwcc_pkg::lwcc_job_t  q_data
);
    import lwcc_pkg::*;

    // stage 1: log of both operands and weight
    function automatic logic [16:0] ln_q12(input logic [23:0] v);
        logic [4:0] m;
        logic [LogTableBits-1:0] f;
        logic [31:0] sh;
        m = 5'd0;
        for (int k = 0; k < 24; k++) begin
            if (v[k]) m = 5'(k);
        end
        sh = {v, 8'd0} >> m;
        f  = sh[LogTableBits-1:0];
        return 17'(m) * 17'(Ln2Q12) + 17'(LnTable[f]);
    endfunction

    logic               s1_valid_reg, s1_last_reg, s1_use_reg;
    logic signed [15:0] s1_x_reg, s1_z_reg;
    logic [17:0]        s1_w_reg;
    logic signed [19:0] ws;

    assign ws = $signed({4'd0, log_weight})
              + $signed({3'd0, ln_q12(in_data.digit_energy)})
              - $signed({3'd0, ln_q12(in_data.cluster_amplitude)});

    // a last digit needs a queue slot, guard the pipeline conservatively
    assign in_ready = !q_full && !(s1_valid_reg && s1_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid && in_ready;
        end
        s1_last_reg <= in_data.last_digit;
        s1_use_reg  <= (in_data.digit_energy != 0) && (in_data.cluster_amplitude != 0);
        s1_x_reg    <= in_data.digit_x;
        s1_z_reg    <= in_data.digit_z;
        s1_w_reg    <= (ws > 0) ? ws[17:0] : 18'd0;
    end

    // stage 2: products and saturating accumulation
    logic signed [39:0] sx_reg, sz_reg, sx_next, sz_next;
    logic [23:0]        sw_reg, sw_next;
    logic signed [41:0] ax, az;
    logic signed [34:0] px_w, pz_w;
    logic [24:0]        aw;
    logic [17:0]        wu;

    always_comb begin
        wu   = s1_use_reg ? s1_w_reg : 18'd0;
        px_w = s1_x_reg * $signed({1'b0, wu});
        pz_w = s1_z_reg * $signed({1'b0, wu});
        ax = 42'(sx_reg) + 42'(px_w);
        az = 42'(sz_reg) + 42'(pz_w);
        aw = {1'b0, sw_reg} + {7'd0, wu};
        sx_next = (ax > 42'(PsumMax)) ? PsumMax : (ax < 42'(PsumMin)) ? PsumMin : ax[39:0];
        sz_next = (az > 42'(PsumMax)) ? PsumMax : (az < 42'(PsumMin)) ? PsumMin : az[39:0];
        sw_next = aw[24] ? WsumMax : aw[23:0];
    end

    assign q_push      = s1_valid_reg && s1_last_reg;
    assign q_data.sum_x = sx_next;
    assign q_data.sum_z = sz_next;
    assign q_data.sum_w = sw_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg <= '0;
            sz_reg <= '0;
            sw_reg <= '0;
        end else if (s1_valid_reg) begin
            sx_reg <= s1_last_reg ? '0 : sx_next;
            sz_reg <= s1_last_reg ? '0 : sz_next;
            sw_reg <= s1_last_reg ? '0 : sw_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/lwcc_queue.sv @@
`default_nettype none
module lwcc_queue (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  lwcc_pkg::lwcc_job_t  push_data,
    output logic                 full,
    output logic                 not_empty,
    input  wire                  pop,
    output lwcc_pkg::lwcc_job_t  pop_data
);
    import lwcc_pkg::*;

    lwcc_job_t       mem [QueueDepth];
    logic [QueueAw-1:0] wp_reg, rp_reg;
    logic [QueueAw:0]   cnt_reg;

    // one slot of margin covers the in-flight front stage
    assign full      = cnt_reg >= (QueueAw+1)'(QueueDepth - 1);
    assign not_empty = cnt_reg != '0;
    assign pop_data  = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= push_data;
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/lwcc_back.sv @@
`default_nettype none
module lwcc_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  job_valid,
    input  lwcc_pkg::lwcc_job_t  job,
    output logic                 job_pop,
    output logic                 out_valid,
    input  wire                  out_ready,
    output lwcc_pkg::lwcc_out_t  out_data
);
    import lwcc_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StDiv  = 2'd1;
    localparam logic [1:0] StFin  = 2'd2;
    localparam logic [1:0] StOut  = 2'd3;
    localparam int DivSteps = 40;

    logic [1:0]  st_reg;
    logic [5:0]  cnt_reg;
    logic        neg_x_reg, neg_z_reg;
    logic [23:0] rx_reg, rz_reg;
    logic [39:0] qx_reg, qz_reg;
    logic [23:0] d_reg;
    lwcc_out_t   out_reg;
    logic [39:0] mag_x, mag_z;
    logic [24:0] tx, tz;
    logic [63:0] ax, az;

    assign mag_x = job.sum_x[39] ? 40'(-job.sum_x) : job.sum_x;
    assign mag_z = job.sum_z[39] ? 40'(-job.sum_z) : job.sum_z;
    // restoring division, one quotient bit per cycle; remainder above dividend
    assign ax = {rx_reg, qx_reg};
    assign az = {rz_reg, qz_reg};
    assign tx = ax[63:39] - {1'b0, d_reg};
    assign tz = az[63:39] - {1'b0, d_reg};

    function automatic logic signed [15:0] clamp(input logic neg, input logic [39:0] q);
        if (!neg) return (q > 40'd32767) ? 16'sd32767 : 16'(q);
        return (q > 40'd32768) ? -16'sd32768 : 16'(-q);
    endfunction

    assign job_pop   = (st_reg == StIdle) && job_valid;
    assign out_valid = (st_reg == StOut);
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= StIdle;
        end else begin
            case (st_reg)
                StIdle: begin
                    if (job_valid) begin
                        if (job.sum_w == '0) begin
                            out_reg <= '0;
                            st_reg  <= StOut;
                        end else begin
                            st_reg <= StDiv;
                        end
                        neg_x_reg <= job.sum_x[39];
                        neg_z_reg <= job.sum_z[39];
                        qx_reg    <= mag_x;
                        qz_reg    <= mag_z;
                        rx_reg    <= '0;
                        rz_reg    <= '0;
                        d_reg     <= job.sum_w;
                        cnt_reg   <= '0;
                    end
                end
                StDiv: begin
                    if (!tx[24]) begin
                        rx_reg <= tx[23:0];
                        qx_reg <= {ax[38:0], 1'b1};
                    end else begin
                        rx_reg <= ax[62:39];
                        qx_reg <= {ax[38:0], 1'b0};
                    end
                    if (!tz[24]) begin
                        rz_reg <= tz[23:0];
                        qz_reg <= {az[38:0], 1'b1};
                    end else begin
                        rz_reg <= az[62:39];
                        qz_reg <= {az[38:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DivSteps - 1)) st_reg <= StFin;
                end
                StFin: begin
                    out_reg.centroid_x     <= clamp(neg_x_reg, qx_reg);
                    out_reg.centroid_z     <= clamp(neg_z_reg, qz_reg);
                    out_reg.position_valid <= 1'b1;
                    st_reg <= StOut;
                end
                StOut: begin
                    if (out_ready) st_reg <= StIdle;
                end
                default: st_reg <= StIdle;
            endcase
        end
    end
endmodule
`default_nettype wire
